[rtl/hop_power_stationarity_detector_assert.svh]
// Assertion macros for the hop power stationarity detector checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef HOP_POWER_STATIONARITY_DETECTOR_ASSERT_SVH
`define HOP_POWER_STATIONARITY_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPSD_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hop power detector check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPSD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hop power detector check failed");

`endif

[rtl/hpsd_pkg.sv]
// Shared constants of the hop power stationarity detector.
// Used by the top level, the iterative divider and the port checker.
`timescale 1ns / 1ps

package hpsd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_W    = 16;
	localparam int MAX_HOP     = 1024;
	localparam int HOP_W       = 11;
	localparam int RET_W       = 16;
	localparam int POWER_W     = 31;
	localparam int SUM_W       = 41;
	localparam int VAR_W       = 61;
	localparam int SQ_W        = 62;
	localparam int MUL_W       = 32;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = 80;
	localparam int FRAC_BITS   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 31;

	localparam int SQ_FRAC = 2 * (SAMPLE_BITS - 1);
	localparam int SQ_SHR  = (SQ_FRAC >= 30) ? SQ_FRAC - 30 : 0;
	localparam int SQ_SHL  = (SQ_FRAC < 30) ? 30 - SQ_FRAC : 0;

	localparam logic [CFG_IDX_W-1:0] CFG_HOP_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETENTION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STAT_THR   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_THR    = 2'd3;

	localparam logic [HOP_W-1:0]   HOP_RESET       = 11'd160;
	localparam logic [RET_W-1:0]   RETENTION_RESET = 16'd64881;
	localparam logic [RET_W-1:0]   STAT_THR_RESET  = 16'd1311;
	localparam logic [POWER_W-1:0] ACT_THR_RESET   = 31'd1074;

	localparam logic [RET_W:0]     RET_ONE   = 17'h10000;
	localparam logic [ACC_W-1:0]   ACC_ROUND = 80'h8000;

endpackage

[rtl/hpsd_div.sv]
// Restoring divider, one quotient bit per cycle, for the hop power mean.
// Depends on hpsd_pkg for the sum, hop and power widths.
`timescale 1ns / 1ps

module hpsd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hpsd_pkg::SUM_W-1:0]   dividend,
	input  logic [hpsd_pkg::HOP_W-1:0]   divisor,
	output logic                         done,
	output logic [hpsd_pkg::POWER_W-1:0] quotient
);
	import hpsd_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [HOP_W-1:0] rem_q;
	logic [HOP_W-1:0] div_q;
	logic [HOP_W:0]   rem_sh;
	logic [HOP_W:0]   rem_diff;
	logic             ge;
	logic [HOP_W-1:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, quo_q[SUM_W-1]};
		rem_diff = rem_sh - {1'b0, div_q};
		ge       = rem_sh >= {1'b0, div_q};
		rem_next = ge ? rem_diff[HOP_W-1:0] : rem_sh[HOP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[POWER_W-1:0];

endmodule

[rtl/hop_power_stationarity_detector.sv]
// Top level of the hop power stationarity detector: registers, sequencer, shared multiplier.
// Depends on hpsd_pkg and instantiates the iterative divider hpsd_div.
`timescale 1ns / 1ps

// Usage: the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready and writes one register per beat; it is meant to be used while the block is idle.
// The input channel takes one Q1.15 sample per beat. A sample that does not close a hop
// is added to the hop sum while in_ready is low, and the block then returns to idle. A
// sample that closes a hop starts a restoring division of the hop sum. For an inactive or
// first active hop the quotient is then loaded into the output register; otherwise the
// envelope averages are updated first. That update runs ten products through one 32 by 32
// multiplier. in_ready rises again as the result is loaded.
// The result sits in an output register, so the next samples are taken while it waits;
// when a further hop closes before the receiver takes the pending result, the block
// holds the new result and keeps in_ready low until the output register frees.
// Reset restores the register defaults and clears the hop sum, sample count, envelope
// mean, envelope variance and both flags.
module hop_power_stationarity_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpsd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [hpsd_pkg::SAMPLE_W-1:0] sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hpsd_pkg::POWER_W-1:0]    far_power,
	output logic                            far_active,
	output logic                            far_stationary
);
	import hpsd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic [3:0] ST_MEAN_A   = 4'd0;
	localparam logic [3:0] ST_MEAN_B   = 4'd1;
	localparam logic [3:0] ST_DIFF_SQ  = 4'd2;
	localparam logic [3:0] ST_VAR_A_LO = 4'd3;
	localparam logic [3:0] ST_VAR_A_HI = 4'd4;
	localparam logic [3:0] ST_VAR_B_LO = 4'd5;
	localparam logic [3:0] ST_VAR_B_HI = 4'd6;
	localparam logic [3:0] ST_MEAN_SQ  = 4'd7;
	localparam logic [3:0] ST_THR_LO   = 4'd8;
	localparam logic [3:0] ST_THR_HI   = 4'd9;

	logic [HOP_W-1:0]   hop_len_q;
	logic [RET_W-1:0]   retention_q;
	logic [RET_W-1:0]   stat_thr_q;
	logic [POWER_W-1:0] act_thr_q;

	logic [2:0]         state_q;
	logic [3:0]         step_q;
	logic               phase_q;
	logic [SUM_W-1:0]   power_sum_q;
	logic [HOP_W-1:0]   sample_cnt_q;
	logic [POWER_W-1:0] mean_q;
	logic [VAR_W-1:0]   var_q;
	logic               active_q;
	logic               stat_q;
	logic               out_valid_q;

	logic [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]   acc_q;
	logic [POWER_W-1:0] p_q;
	logic [POWER_W-1:0] diff_q;
	logic [SQ_W-1:0]    d2_q;
	logic [SQ_W-1:0]    m2_q;
	logic [POWER_W-1:0] far_power_q;
	logic               out_act_q;
	logic               out_stat_q;

	logic [SAMPLE_BITS-1:0] smp_bits;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SUM_W-1:0]   square_q30;
	logic [SUM_W-1:0]   sum_next;
	logic [HOP_W-1:0]   count_next;
	logic [HOP_W-1:0]   hop_eff;
	logic               hop_close;
	logic [RET_W:0]     weight_b;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic               acc_clear;
	logic               acc_round;
	logic               acc_high;
	logic [ACC_W-1:0]   acc_base;
	logic [ACC_W-1:0]   acc_addend;
	logic [ACC_W-1:0]   acc_sum;
	logic               out_load;
	logic               div_start;
	logic               div_done;
	logic [POWER_W-1:0] div_quo;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_len_q   <= HOP_RESET;
			retention_q <= RETENTION_RESET;
			stat_thr_q  <= STAT_THR_RESET;
			act_thr_q   <= ACT_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HOP_LENGTH: hop_len_q   <= cfg_data[HOP_W-1:0];
				CFG_RETENTION:  retention_q <= cfg_data[RET_W-1:0];
				CFG_STAT_THR:   stat_thr_q  <= cfg_data[RET_W-1:0];
				CFG_ACT_THR:    act_thr_q   <= cfg_data[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		smp_bits   = sample[SAMPLE_BITS-1:0];
		mag        = smp_bits[SAMPLE_BITS-1] ? (~smp_bits + 1'b1) : smp_bits;
		square_q30 = SUM_W'((prod_q >> SQ_SHR) << SQ_SHL);
		sum_next   = power_sum_q + square_q30;
		count_next = sample_cnt_q + 1'b1;
		if (hop_len_q == '0) begin
			hop_eff = HOP_W'(1);
		end else if (32'(hop_len_q) > MAX_HOP) begin
			hop_eff = HOP_W'(MAX_HOP);
		end else begin
			hop_eff = hop_len_q;
		end
		hop_close = (count_next == '0) || (count_next >= hop_eff);
		weight_b  = RET_ONE - {1'b0, retention_q};
		div_start = (state_q == S_ACC) && hop_close;
		out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		mul_a = MUL_W'(mag);
		mul_b = MUL_W'(mag);
		if (state_q == S_MUL) begin
			case (step_q)
				ST_MEAN_A: begin
					mul_a = MUL_W'(retention_q);
					mul_b = MUL_W'(mean_q);
				end
				ST_MEAN_B: begin
					mul_a = MUL_W'(weight_b);
					mul_b = MUL_W'(p_q);
				end
				ST_DIFF_SQ: begin
					mul_a = MUL_W'(diff_q);
					mul_b = MUL_W'(diff_q);
				end
				ST_VAR_A_LO: begin
					mul_a = MUL_W'(retention_q);
					mul_b = var_q[MUL_W-1:0];
				end
				ST_VAR_A_HI: begin
					mul_a = MUL_W'(retention_q);
					mul_b = MUL_W'(var_q[VAR_W-1:MUL_W]);
				end
				ST_VAR_B_LO: begin
					mul_a = MUL_W'(weight_b);
					mul_b = d2_q[MUL_W-1:0];
				end
				ST_VAR_B_HI: begin
					mul_a = MUL_W'(weight_b);
					mul_b = MUL_W'(d2_q[SQ_W-1:MUL_W]);
				end
				ST_MEAN_SQ: begin
					mul_a = MUL_W'(mean_q);
					mul_b = MUL_W'(mean_q);
				end
				ST_THR_LO: begin
					mul_a = MUL_W'(stat_thr_q);
					mul_b = m2_q[MUL_W-1:0];
				end
				ST_THR_HI: begin
					mul_a = MUL_W'(stat_thr_q);
					mul_b = MUL_W'(m2_q[SQ_W-1:MUL_W]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	always_comb begin
		acc_clear = 1'b0;
		acc_round = 1'b0;
		acc_high  = 1'b0;
		case (step_q)
			ST_MEAN_A: begin
				acc_clear = 1'b1;
				acc_round = 1'b1;
			end
			ST_VAR_A_LO: begin
				acc_clear = 1'b1;
				acc_round = 1'b1;
			end
			ST_VAR_A_HI: acc_high  = 1'b1;
			ST_VAR_B_HI: acc_high  = 1'b1;
			ST_THR_LO:   acc_clear = 1'b1;
			ST_THR_HI:   acc_high  = 1'b1;
			default: ;
		endcase
		acc_addend = acc_high ? (ACC_W'(prod_q) << MUL_W) : ACC_W'(prod_q);
		acc_base   = acc_clear ? (acc_round ? ACC_ROUND : '0) : acc_q;
		acc_sum    = acc_base + acc_addend;
	end

	hpsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (hop_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			phase_q      <= 1'b0;
			power_sum_q  <= '0;
			sample_cnt_q <= '0;
			mean_q       <= '0;
			var_q        <= '0;
			active_q     <= 1'b0;
			stat_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (hop_close) begin
						power_sum_q  <= '0;
						sample_cnt_q <= '0;
						state_q      <= S_DIV;
					end else begin
						power_sum_q  <= sum_next;
						sample_cnt_q <= count_next;
						state_q      <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (p_q > act_thr_q) begin
						if (!active_q) begin
							mean_q   <= p_q;
							var_q    <= '0;
							active_q <= 1'b1;
							stat_q   <= 1'b0;
							state_q  <= S_OUT;
						end else begin
							step_q  <= ST_MEAN_A;
							phase_q <= 1'b0;
							state_q <= S_MUL;
						end
					end else begin
						active_q <= 1'b0;
						stat_q   <= 1'b0;
						state_q  <= S_OUT;
					end
				end
				S_MUL: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						step_q  <= step_q + 1'b1;
						case (step_q)
							ST_MEAN_B:   mean_q <= acc_sum[POWER_W+FRAC_BITS-1:FRAC_BITS];
							ST_VAR_B_HI: var_q  <= acc_sum[VAR_W+FRAC_BITS-1:FRAC_BITS];
							ST_THR_HI: begin
								stat_q  <= ACC_W'({var_q, {FRAC_BITS{1'b0}}}) < acc_sum;
								state_q <= S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_DIV && div_done) begin
			p_q <= div_quo;
		end
		if (state_q == S_EVAL) begin
			diff_q <= (p_q >= mean_q) ? (p_q - mean_q) : (mean_q - p_q);
		end
		if (state_q == S_MUL && phase_q) begin
			acc_q <= acc_sum;
			if (step_q == ST_DIFF_SQ) begin
				d2_q <= prod_q[SQ_W-1:0];
			end
			if (step_q == ST_MEAN_SQ) begin
				m2_q <= prod_q[SQ_W-1:0];
			end
		end
		if (out_load) begin
			far_power_q <= p_q;
			out_act_q   <= active_q;
			out_stat_q  <= stat_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign far_power      = far_power_q;
	assign far_active     = out_act_q;
	assign far_stationary = out_stat_q;

endmodule

[rtl/hpsd_chk.sv]
// Port-level checker for the hop power stationarity detector, bound to the top level.
// Depends on hpsd_pkg and the assertion macros in the detector's assertion header.
`timescale 1ns / 1ps
`include "hop_power_stationarity_detector_assert.svh"

module hpsd_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [hpsd_pkg::POWER_W-1:0] far_power,
	input logic                         far_active,
	input logic                         far_stationary
);
	import hpsd_pkg::*;

	// A stalled result beat keeps its payload.
	`HPSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(far_power) && $stable(far_active) && $stable(far_stationary))

	// Stationarity is only ever reported for an active hop.
	`HPSD_ASSERT_IMPL(a_stat_needs_active, out_valid, far_active || !far_stationary)

	// Every sample beat is followed by a busy period with in_ready low.
	`HPSD_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)

	// A new result only appears at the end of a busy period.
	`HPSD_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind hop_power_stationarity_detector hpsd_chk u_hpsd_chk (.*);
